// ----- src/assert_macros.svh -----
// assertion macros used by the console renderer sequencer module
// no dependencies; each user supplies i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stcr_pkg.sv -----
// shared types and constants of the scaled text console renderer
// no dependencies
`default_nettype none

package stcr_pkg;

    localparam int GLYPH_ROWS   = 16;
    localparam int MAX_SCALE    = 4;
    localparam int LINE_ADVANCE = 20;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_IDX_W  = 8;

    typedef enum logic [1:0] {
        ACT_LOAD_FONT  = 2'd0,
        ACT_SET_CURSOR = 2'd1,
        ACT_CHAR       = 2'd2,
        ACT_NONE       = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPAN,
        S_SCROLL
    } t_state;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;

    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 8'd3;

    // settings seen by the sequencer, scale already clamped to 1..4
    typedef struct packed {
        logic [31:0] fore_color;
        logic [2:0]  scale;
        logic [12:0] screen_rows;
    } t_cfg;

    // glyph store access
    typedef struct packed {
        logic        we;
        logic [11:0] waddr;
        logic [7:0]  wdata;
        logic [11:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- src/stcr_glyph_ram.sv -----
// glyph store: 4096 x 8 bits, one write and one registered read port
// no dependencies
`default_nettype none

module stcr_glyph_ram (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [11:0] i_waddr,
    input  wire logic [7:0]  i_wdata,
    input  wire logic [11:0] i_raddr,
    output logic      [7:0]  o_rdata
);

    logic [7:0] r_mem [4096];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/stcr_seq.sv -----
// action sequencer: cursor state, span counters, span row adder, output register
// depends on stcr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stcr_seq (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire stcr_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [1:0]                       i_s_tuser,
    input  wire logic [stcr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast,
    output logic      [stcr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output stcr_pkg::t_ram_req                    o_ram,
    input  wire logic [7:0]                       i_rd_data
);

    import stcr_pkg::*;

    function automatic logic [31:0] expand_row(logic [7:0] bits, logic [2:0] scale);
        logic [31:0] mask;
        int          pos;
        mask = '0;
        for (int j = 0; j < 8; j++) begin
            for (int k = 0; k < MAX_SCALE; k++) begin
                pos = j * int'(scale) + k;
                if (k < int'(scale) && bits[7-j] && pos < 32) begin
                    mask[31-pos] = 1'b1;
                end
            end
        end
        return mask;
    endfunction

    t_state      r_state, n_state;
    logic [15:0] r_cur_col, n_cur_col;
    logic [15:0] r_cur_row, n_cur_row;
    logic [1:0]  r_k, n_k;
    logic [3:0]  r_g, n_g;
    logic [15:0] r_row, n_row;
    logic [7:0]  r_code, n_code;
    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind;
    logic        r_out_last, n_out_last;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    t_action     w_act;
    logic [11:0] w_font_addr;
    logic [7:0]  w_font_data;
    logic [7:0]  w_code;
    logic [15:0] w_set_x;
    logic [15:0] w_set_y;
    logic        w_accept;
    logic        w_out_free;
    logic        w_emit;
    logic        w_last_span;
    logic [2:0]  w_k_next;
    logic [5:0]  w_cell;
    logic [17:0] w_need;
    logic        w_fit;
    logic        w_is_nl;
    logic        w_is_bs;

    assign w_act       = t_action'(i_s_tuser);
    assign w_font_addr = i_s_tdata[11:0];
    assign w_font_data = i_s_tdata[19:12];
    assign w_code      = i_s_tdata[27:20];
    assign w_set_x     = i_s_tdata[43:28];
    assign w_set_y     = i_s_tdata[59:44];

    // nothing is taken while reset is held
    assign o_s_tready  = (r_state == S_IDLE) && i_rst_n;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_emit      = (r_state == S_SPAN) && w_out_free;
    assign w_k_next    = {1'b0, r_k} + 3'd1;
    assign w_last_span = (r_g == 4'hF) && (w_k_next == i_cfg.scale);
    assign w_cell      = {i_cfg.scale, 3'b000};
    assign w_is_nl     = (w_code == CODE_NEWLINE);
    assign w_is_bs     = (w_code == CODE_BACKSPACE);

    // newline fit test, no wrap
    assign w_need = {2'b00, r_cur_row} + 18'(LINE_ADVANCE) + {11'd0, i_cfg.scale, 4'b0000};
    assign w_fit  = (w_need <= {5'd0, i_cfg.screen_rows});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_act == ACT_CHAR) begin
                    if (w_is_nl) begin
                        if (!w_fit) n_state = S_SCROLL;
                    end else if (!w_is_bs) begin
                        n_state = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                if (w_emit && w_last_span) n_state = S_IDLE;
            end
            S_SCROLL: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_k         = r_k;
        n_g         = r_g;
        n_row       = r_row;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        n_out_data  = r_out_data;
        o_ram.we    = 1'b0;
        o_ram.waddr = w_font_addr;
        o_ram.wdata = w_font_data;
        o_ram.raddr = {w_code, 4'h0};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_act)
                        ACT_LOAD_FONT: o_ram.we = 1'b1;
                        ACT_SET_CURSOR: begin
                            n_cur_col = w_set_x;
                            n_cur_row = w_set_y;
                        end
                        ACT_CHAR: begin
                            if (w_is_nl) begin
                                n_cur_col = '0;
                                if (w_fit) n_cur_row = r_cur_row + 16'(LINE_ADVANCE);
                            end else if (w_is_bs) begin
                                if (r_cur_col >= {10'd0, w_cell}) begin
                                    n_cur_col = r_cur_col - {10'd0, w_cell};
                                end
                            end else begin
                                n_k    = '0;
                                n_g    = '0;
                                n_row  = r_cur_row;
                                n_code = w_code;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SPAN: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SPAN;
                    n_out_last  = w_last_span;
                    n_out_data  = {2'b00, i_cfg.fore_color,
                                   expand_row(i_rd_data, i_cfg.scale),
                                   w_cell, r_cur_col, r_row};
                    n_row       = r_row + 16'd1;
                    if (w_k_next == i_cfg.scale) begin
                        n_k = '0;
                        n_g = r_g + 4'd1;
                    end else begin
                        n_k = w_k_next[1:0];
                    end
                    if (w_last_span) n_cur_col = r_cur_col + {10'd0, w_cell};
                end
                // prefetch the glyph row of the next span
                o_ram.raddr = {r_code, n_g};
            end
            S_SCROLL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SCROLL;
                    n_out_last  = 1'b1;
                    n_out_data  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_k         <= '0;
            r_g         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_k         <= n_k;
            r_g         <= n_g;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_code     <= n_code;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = r_out_data;

    `ASSERT_AT_CLK(a_rep_in_range, (r_state == S_SPAN) |-> (w_k_next <= i_cfg.scale),
        "span repeat counter beyond scale")
    `ASSERT_NEXT(a_last_span_idles, w_emit && w_last_span, r_state == S_IDLE,
        "sequencer busy after final span")
    `ASSERT_NEXT(a_row_steps, w_emit && !w_last_span, r_row == $past(r_row) + 16'd1,
        "span row did not advance by one")

endmodule

`default_nettype wire

// ----- src/scaled_text_console_renderer.sv -----
// character item: 16*scale spans, one span per cycle while the output is not stalled;
// that rate is set by the one glyph store read port and the span row adder; no new item is taken meanwhile
// newline that scrolls: one result; other items give no result
// result register lets the next item enter while a finished result waits downstream
// i_rst_n synchronous active low: cursor to 0, settings to reset values; glyph store is
// not cleared and must be loaded before use, so there is no clearing pass after reset
`default_nettype none

module scaled_text_console_renderer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // settings write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [stcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [31:0]                         i_cfg_data,
    // action items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [1:0]                          s_axis_tuser,   // action
    // font_address[11:0] font_data[19:12] char_code[27:20] set_x[43:28] set_y[59:44]
    input  wire logic [stcr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic                                     m_axis_tuser,   // kind
    output logic                                     m_axis_tlast,   // last
    // span_row[15:0] span_column[31:16] span_width[37:32] pixel_mask[69:38]
    // span_color[101:70], zero fill above
    output logic      [stcr_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import stcr_pkg::*;

    // settings registers; screen width only matters downstream, so it is not held
    logic [31:0] r_fore_color, n_fore_color;
    logic [2:0]  r_pixel_scale, n_pixel_scale;
    logic [12:0] r_screen_rows, n_screen_rows;

    t_cfg        w_cfg;
    t_ram_req    w_ram;
    logic [7:0]  w_rd_data;
    logic        w_cfg_wr;

    // no writes are taken while reset is held
    assign o_cfg_ready = i_rst_n;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_fore_color  = r_fore_color;
        n_pixel_scale = r_pixel_scale;
        n_screen_rows = r_screen_rows;
        if (w_cfg_wr) begin
            case (i_cfg_index)
                REG_FORE_COLOR:     n_fore_color  = i_cfg_data;
                REG_PIXEL_SCALE:    n_pixel_scale = i_cfg_data[2:0];
                REG_SCREEN_COLUMNS: ; // passed on downstream, no effect here
                REG_SCREEN_ROWS:    n_screen_rows = i_cfg_data[12:0];
                default: ;            // unknown index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore_color  <= 32'h00FF_FFFF;
            r_pixel_scale <= 3'd1;
            r_screen_rows <= 13'd768;
        end else begin
            r_fore_color  <= n_fore_color;
            r_pixel_scale <= n_pixel_scale;
            r_screen_rows <= n_screen_rows;
        end
    end

    // scale of zero acts as one, above four acts as four
    always_comb begin
        w_cfg.fore_color  = r_fore_color;
        w_cfg.screen_rows = r_screen_rows;
        if (r_pixel_scale == 3'd0) begin
            w_cfg.scale = 3'd1;
        end else if (r_pixel_scale > 3'(MAX_SCALE)) begin
            w_cfg.scale = 3'(MAX_SCALE);
        end else begin
            w_cfg.scale = r_pixel_scale;
        end
    end

    // glyph store, written by font load items and read once per span
    stcr_glyph_ram u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    // sequencer holding the cursor and the result register
    stcr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tdata  (m_axis_tdata),
        .o_ram      (w_ram),
        .i_rd_data  (w_rd_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking bench for the scaled text console renderer: directed table, then random phases
// depends on stcr_pkg and scaled_text_console_renderer; spans are predicted per accepted item
module tb_top;
    import stcr_pkg::*;

    localparam int CLK_HALF            = 5;
    localparam int RESET_CYCLES        = 5;
    localparam int SETTLE_CYCLES       = 80;      // covers the longest busy stretch, a character at scale 4
    localparam int DRAIN_LIMIT         = 50000;
    localparam int TIMEOUT_CYCLES      = 1500000;
    localparam int LONG_STALL_CYCLES   = 400;
    localparam int PHASE_COUNT         = 6;
    localparam int ITEMS_PER_PHASE     = 30;

    // register indexes outside the map, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    // how the result of a table row is checked
    typedef enum logic [1:0] {
        CHECK_PREDICTED,   // spans worked out by the predictor
        CHECK_QUIET,       // the item must cause no result at all
        CHECK_SCROLL       // exactly one scroll command
    } t_check_mode;

    typedef struct packed {
        t_action     action;
        logic [11:0] font_address;
        logic [7:0]  font_data;
        logic [7:0]  char_code;
        logic [15:0] set_x;
        logic [15:0] set_y;
    } t_action_item;

    typedef struct packed {
        logic        kind;
        logic [15:0] row;
        logic [15:0] column;
        logic [5:0]  width;
        logic [31:0] mask;
        logic [31:0] color;
        logic        last;
    } t_span;

    typedef struct packed {
        t_check_mode  mode;
        t_action_item item;
    } t_plan_row;

    // scroll command: every field but kind and last is zero
    localparam t_span SCROLL_ITEM = {KIND_SCROLL, 16'd0, 16'd0, 6'd0, 32'd0, 32'd0, 1'b1};

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [31:0]           i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [1:0]            s_axis_tuser;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // travels alongside each action item so the monitor knows how to check it
    t_check_mode           in_mode;

    always #CLK_HALF i_clk = ~i_clk;

    scaled_text_console_renderer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // predictor state: cursor, glyph store and the settings in force
    // ------------------------------------------------------------------
    logic [15:0] cur_col;
    logic [15:0] cur_row;
    logic [7:0]  glyph_store [0:4095];
    logic [31:0] cfg_color;
    logic [2:0]  cfg_scale;
    logic [12:0] cfg_rows;

    t_span       fresh_spans [0:63];   // results of the item just accepted
    t_span       pending_spans [$];    // results still owed by the block

    // stimulus bookkeeping: which store bytes were written, which glyphs are whole
    bit          glyph_written [0:4095];
    bit          code_listed [0:255];
    logic [7:0]  ready_codes [$];
    t_plan_row   directed_plan [$];

    int unsigned sender_idle_pct   = 20;
    int unsigned receiver_idle_pct = 20;
    bit          long_stall_request = 1'b0;
    int          mismatch_count = 0;

    // one line per mismatch, and counted
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // works out the spans one action causes, updating cursor and store as the block does
    function automatic int render_action(input t_action_item it);
        int unsigned scale;
        int unsigned span_px;
        int unsigned total;
        int unsigned need;
        int unsigned i;
        int unsigned j;
        int unsigned k;
        logic [7:0]  bits;
        logic [31:0] mask;
        int          count;

        // scale 0 behaves as 1, anything above the maximum as the maximum
        if (cfg_scale == 3'd0)
            scale = 1;
        else if (32'(cfg_scale) > MAX_SCALE)
            scale = MAX_SCALE;
        else
            scale = 32'(cfg_scale);
        span_px = 8 * scale;
        count   = 0;

        case (it.action)
            ACT_LOAD_FONT: glyph_store[it.font_address] = it.font_data;
            ACT_SET_CURSOR: begin
                cur_col = it.set_x;
                cur_row = it.set_y;
            end
            ACT_CHAR: begin
                if (it.char_code == CODE_NEWLINE) begin
                    // fit test is done at full width, no wrap
                    need = 32'(cur_row) + LINE_ADVANCE + GLYPH_ROWS * scale;
                    if (need <= 32'(cfg_rows)) begin
                        cur_row = cur_row + 16'(LINE_ADVANCE);
                    end else begin
                        fresh_spans[0] = SCROLL_ITEM;
                        count = 1;
                    end
                    cur_col = 16'd0;
                end else if (it.char_code == CODE_BACKSPACE) begin
                    if (32'(cur_col) >= span_px)
                        cur_col = cur_col - 16'(span_px);
                end else begin
                    total = GLYPH_ROWS * scale;
                    for (i = 0; i < total; i++) begin
                        bits = glyph_store[{it.char_code, 4'(i / scale)}];
                        mask = 32'd0;
                        // each glyph bit repeated scale times, leftmost pixel in bit 31
                        for (j = 0; j < 8; j++)
                            for (k = 0; k < scale; k++)
                                if (bits[7 - j])
                                    mask[31 - (j * scale + k)] = 1'b1;
                        fresh_spans[i].kind   = KIND_SPAN;
                        fresh_spans[i].row    = cur_row + 16'(i);
                        fresh_spans[i].column = cur_col;
                        fresh_spans[i].width  = 6'(span_px);
                        fresh_spans[i].mask   = mask;
                        fresh_spans[i].color  = cfg_color;
                        fresh_spans[i].last   = (i + 1 == total);
                    end
                    count   = int'(total);
                    cur_col = cur_col + 16'(span_px);
                end
            end
            default: ;
        endcase
        return count;
    endfunction

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------

    // settings take effect in the predictor on the write handshake
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FORE_COLOR:  cfg_color = i_cfg_data;
                REG_PIXEL_SCALE: cfg_scale = i_cfg_data[2:0];
                REG_SCREEN_ROWS: cfg_rows  = i_cfg_data[12:0];
                default: ;      // screen width has no effect on results
            endcase
        end
    end

    // every accepted action item is run through the predictor
    always @(posedge i_clk) begin : action_monitor
        t_action_item seen;
        int           n;
        int           idx;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.action       = t_action'(s_axis_tuser);
            seen.font_address = s_axis_tdata[11:0];
            seen.font_data    = s_axis_tdata[19:12];
            seen.char_code    = s_axis_tdata[27:20];
            seen.set_x        = s_axis_tdata[43:28];
            seen.set_y        = s_axis_tdata[59:44];
            n = render_action(seen);
            case (in_mode)
                CHECK_PREDICTED:
                    for (idx = 0; idx < n; idx++) pending_spans.push_back(fresh_spans[idx]);
                CHECK_SCROLL: pending_spans.push_back(SCROLL_ITEM);
                default: ;
            endcase
        end
    end

    // each result item is held against the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_span got;
        t_span want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind   = m_axis_tuser;
            got.row    = m_axis_tdata[15:0];
            got.column = m_axis_tdata[31:16];
            got.width  = m_axis_tdata[37:32];
            got.mask   = m_axis_tdata[69:38];
            got.color  = m_axis_tdata[101:70];
            got.last   = m_axis_tlast;
            if (pending_spans.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tdata %h",
                                          m_axis_tdata));
            end else begin
                want = pending_spans.pop_front();
                check_field("kind",   32'(got.kind),   32'(want.kind));
                check_field("row",    32'(got.row),    32'(want.row));
                check_field("column", 32'(got.column), 32'(want.column));
                check_field("width",  32'(got.width),  32'(want.width));
                check_field("mask",   got.mask,        want.mask);
                check_field("color",  got.color,       want.color);
                check_field("last",   32'(got.last),   32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // result sink: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        forever begin
            if (long_stall_request) begin
                long_stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                // the block fills up behind this and must stall its input
                for (hold = 0; hold < LONG_STALL_CYCLES; hold++) @(posedge i_clk);
            end else if ($urandom_range(1, 100) <= receiver_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random content in every field, the action given
    function automatic t_action_item noise_item(input t_action act);
        t_action_item it;
        it.action       = act;
        it.font_address = 12'($urandom());
        it.font_data    = 8'($urandom());
        it.char_code    = 8'($urandom());
        it.set_x        = 16'($urandom());
        it.set_y        = 16'($urandom());
        return it;
    endfunction

    // a glyph is only drawn once all its 16 rows have been written
    function automatic void note_load(input logic [11:0] addr);
        bit full;
        int r;
        glyph_written[addr] = 1'b1;
        full = 1'b1;
        for (r = 0; r < 16; r++)
            if (!glyph_written[{addr[11:4], 4'(r)}]) full = 1'b0;
        if (full && !code_listed[addr[11:4]]) begin
            code_listed[addr[11:4]] = 1'b1;
            ready_codes.push_back(addr[11:4]);
        end
    endfunction

    function automatic void plan(input t_check_mode mode, input t_action act,
                                 input logic [11:0] addr, input logic [7:0] data,
                                 input logic [7:0] code, input logic [15:0] x,
                                 input logic [15:0] y);
        t_plan_row row;
        row.mode              = mode;
        row.item.action       = act;
        row.item.font_address = addr;
        row.item.font_data    = data;
        row.item.char_code    = code;
        row.item.set_x        = x;
        row.item.set_y        = y;
        directed_plan.push_back(row);
    endfunction

    // offers one action item, with an optional idle burst first, and waits for acceptance
    task automatic send_item(input t_action_item it, input t_check_mode mode);
        if ($urandom_range(1, 100) <= sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        if (it.action == ACT_LOAD_FONT) note_load(it.font_address);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {4'd0, it.set_y, it.set_x, it.char_code, it.font_data,
                          it.font_address};
        in_mode       <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // one write on the settings channel; valid is left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        // junk above the field width must be dropped by the block
        i_cfg_data  <= (width >= 32) ? value : ((32'($urandom()) << width) | value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] color, input logic [2:0] scale,
                                  input logic [12:0] columns, input logic [12:0] rows,
                                  input bit poke_unused);
        write_reg(REG_FORE_COLOR, color, 32);
        write_reg(REG_PIXEL_SCALE, 32'(scale), 3);
        write_reg(REG_SCREEN_COLUMNS, 32'(columns), 13);
        write_reg(REG_SCREEN_ROWS, 32'(rows), 13);
        if (poke_unused) begin
            write_reg(REG_UNUSED_LOW, 32'($urandom()), 32);
            write_reg(REG_UNUSED_HIGH, 32'($urandom()), 32);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // waits until every owed result has arrived, then lets the block settle
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_spans.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_spans.size()));
            pending_spans.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one random step: mostly whole glyph loads and text, some noise and broken loads
    task automatic random_step(input int unsigned roll, output int counted);
        t_action_item it;
        logic [7:0]   code;
        int           r;
        int           first;
        int           len;

        counted = 1;
        it = noise_item(ACT_CHAR);
        if (roll < 45) begin
            it.char_code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
            send_item(it, CHECK_PREDICTED);
        end else if (roll < 57) begin
            it.char_code = CODE_NEWLINE;
            send_item(it, CHECK_PREDICTED);
        end else if (roll < 65) begin
            it.char_code = CODE_BACKSPACE;
            send_item(it, CHECK_PREDICTED);
        end else if (roll < 75) begin
            it = noise_item(ACT_SET_CURSOR);
            case ($urandom_range(0, 2))
                0: ;    // anywhere
                1: begin
                    // close to the top of the 16-bit range: wrap of rows and columns
                    it.set_x = 16'hFFFF - 16'($urandom_range(0, 40));
                    it.set_y = 16'hFFFF - 16'($urandom_range(0, 40));
                end
                default: begin
                    // on a plausible screen, so newlines fit now and then
                    it.set_x = 16'($urandom_range(0, 300));
                    it.set_y = 16'($urandom_range(0, 1000));
                end
            endcase
            send_item(it, CHECK_PREDICTED);
        end else if (roll < 85) begin
            // whole glyph, all 16 rows
            code = 8'($urandom());
            for (r = 0; r < 16; r++) begin
                it = noise_item(ACT_LOAD_FONT);
                it.font_address = {code, 4'(r)};
                send_item(it, CHECK_PREDICTED);
            end
            counted = 16;
        end else if (roll < 90) begin
            // broken load: part of a glyph, rows wrap within the same code
            code  = 8'($urandom());
            first = $urandom_range(0, 15);
            len   = $urandom_range(1, 15);
            for (r = 0; r < len; r++) begin
                it = noise_item(ACT_LOAD_FONT);
                it.font_address = {code, 4'(first + r)};
                send_item(it, CHECK_PREDICTED);
            end
            counted = len;
        end else if (roll < 95) begin
            send_item(noise_item(ACT_LOAD_FONT), CHECK_PREDICTED);
        end else begin
            // unused action, the block must ignore it
            send_item(noise_item(ACT_NONE), CHECK_PREDICTED);
            counted = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------
    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int          r;
        int          phase;
        int          sent;
        int          n;
        logic [7:0]  pattern;

        // every input known from the first step
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= ACT_NONE;
        s_axis_tdata  <= '0;
        in_mode       <= CHECK_QUIET;

        // predictor at its reset values
        cur_col   = 16'd0;
        cur_row   = 16'd0;
        cfg_color = 32'h00FF_FFFF;
        cfg_scale = 3'd1;
        cfg_rows  = 13'd768;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // font preload: glyphs 0 and 255, touching both ends of the store
        for (r = 0; r < 16; r++) begin
            pattern = (r == 0) ? 8'hFF : (r == 15) ? 8'h00 : ((8'h80 >> r[2:0]) | 8'h01);
            plan(CHECK_QUIET, ACT_LOAD_FONT, {8'h00, 4'(r)}, pattern, 8'h00, 16'h0, 16'h0);
            plan(CHECK_QUIET, ACT_LOAD_FONT, {8'hFF, 4'(r)}, ~pattern, 8'hFF,
                 16'hFFFF, 16'hFFFF);
        end

        // directed part at reset settings: scale 1, 768 rows
        plan(CHECK_PREDICTED, ACT_CHAR,       12'h000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        // extreme cursor: span rows and the column wrap
        plan(CHECK_QUIET,     ACT_SET_CURSOR, 12'h000, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
        plan(CHECK_PREDICTED, ACT_CHAR,       12'h000, 8'h00, 8'hFF, 16'h0000, 16'h0000);
        // newline that cannot fit: scroll, column back to 0
        plan(CHECK_SCROLL,    ACT_CHAR,       12'h000, 8'h00, CODE_NEWLINE, 16'h0, 16'h0);
        // backspace with no room: cursor stays
        plan(CHECK_QUIET,     ACT_CHAR,       12'h000, 8'h00, CODE_BACKSPACE, 16'h0, 16'h0);
        plan(CHECK_QUIET,     ACT_SET_CURSOR, 12'hFFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000);
        // newline that fits: no result
        plan(CHECK_QUIET,     ACT_CHAR,       12'h000, 8'h00, CODE_NEWLINE, 16'h0, 16'h0);
        plan(CHECK_PREDICTED, ACT_CHAR,       12'h000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        // backspace with room: steps back one glyph width
        plan(CHECK_QUIET,     ACT_CHAR,       12'h000, 8'h00, CODE_BACKSPACE, 16'h0, 16'h0);
        plan(CHECK_PREDICTED, ACT_CHAR,       12'h000, 8'h00, 8'hFF, 16'h0000, 16'h0000);
        // unused action with all ones; an all-zeros one follows later
        plan(CHECK_QUIET,     ACT_NONE,       12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        // newline fit test right at the boundary, then past it
        plan(CHECK_QUIET,     ACT_SET_CURSOR, 12'h000, 8'h00, 8'h00, 16'd0, 16'd732);
        plan(CHECK_QUIET,     ACT_CHAR,       12'h000, 8'h00, CODE_NEWLINE, 16'h0, 16'h0);
        plan(CHECK_SCROLL,    ACT_CHAR,       12'h000, 8'h00, CODE_NEWLINE, 16'h0, 16'h0);
        // overwrite a glyph row and draw with it
        plan(CHECK_QUIET,     ACT_LOAD_FONT,  12'h000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        plan(CHECK_PREDICTED, ACT_CHAR,       12'h000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        plan(CHECK_QUIET,     ACT_NONE,       12'h000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        plan(CHECK_PREDICTED, ACT_CHAR,       12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);

        foreach (directed_plan[k])
            send_item(directed_plan[k].item, directed_plan[k].mode);
        s_axis_tvalid <= 1'b0;
        drain_and_settle();

        // random phases, each under its own settings, written while idle
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    // sizes of one, largest scale: every newline scrolls
                    apply_settings(32'h0000_0000, 3'd4, 13'd1, 13'd1, 1'b1);
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 15;
                end
                1: begin
                    apply_settings(32'hFFFF_FFFF, 3'd1, 13'd4096, 13'd4096, 1'b0);
                    sender_idle_pct   = 30;
                    receiver_idle_pct = 30;
                end
                2: begin
                    // scale 0 acts as 1, widest row field
                    apply_settings($urandom(), 3'd0, 13'd0, 13'd8191, 1'b0);
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
                3: begin
                    // scale above the maximum acts as the maximum
                    apply_settings($urandom(), 3'd7, 13'($urandom()),
                                   13'($urandom_range(60, 400)), 1'b0);
                    sender_idle_pct   = 15;
                    receiver_idle_pct = 40;
                end
                4: begin
                    apply_settings($urandom(), 3'd2, 13'd8191, 13'd0, 1'b0);
                    sender_idle_pct   = 40;
                    receiver_idle_pct = 15;
                end
                default: begin
                    // closing stretch with no idling on either side
                    apply_settings($urandom(), 3'd3, 13'($urandom()),
                                   13'($urandom_range(100, 1000)), 1'b0);
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            @(posedge i_clk);

            sent = 0;
            if (phase == 0) begin
                // long hold-off downstream while characters keep coming
                long_stall_request = 1'b1;
                repeat (3) begin
                    random_step(0, n);
                    sent += n;
                end
            end
            while (sent < ITEMS_PER_PHASE) begin
                random_step($urandom_range(0, 99), n);
                sent += n;
            end
            s_axis_tvalid <= 1'b0;
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
